@@ sv/chunked_message_file_validator_unit_assert.svh @@
// Assertion helpers shared by the validator modules.
// Each check is sampled on the rising clock edge and is switched off while reset is high.
`ifndef CHUNKED_MESSAGE_FILE_VALIDATOR_UNIT_ASSERT_SVH
`define CHUNKED_MESSAGE_FILE_VALIDATOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define CMFV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CMFV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/cmfv_pkg.sv @@
`default_nettype none
package cmfv_pkg;

   localparam logic [31:0] HDR_LEN       = 32'h20;
   localparam logic [31:0] OFS_SIZE      = 32'h08;
   localparam logic [31:0] OFS_ENC       = 32'h10;
   localparam logic [31:0] BLOCK_HDR_LEN = 32'h08;
   localparam int          REV_XOR       = 3;

   localparam logic [31:0] TAG_MESG = "MESG";
   localparam logic [31:0] TAG_BMG1 = "bmg1";
   localparam logic [31:0] TAG_INF1 = "INF1";
   localparam logic [31:0] TAG_DAT1 = "DAT1";

   localparam logic [7:0] MAX_ENC_RESET = 8'd4;

   localparam logic [2:0] ERR_OK        = 3'd0;
   localparam logic [2:0] ERR_SHORT     = 3'd1;
   localparam logic [2:0] ERR_CONTAINER = 3'd2;
   localparam logic [2:0] ERR_SIGNATURE = 3'd3;
   localparam logic [2:0] ERR_TYPE      = 3'd4;
   localparam logic [2:0] ERR_ENCODING  = 3'd5;
   localparam logic [2:0] ERR_NO_INFO   = 3'd6;
   localparam logic [2:0] ERR_NO_DATA   = 3'd7;

   // One accepted byte, as seen by a chain walker.
   typedef struct packed {
      logic        take;
      logic        clear;
      logic [31:0] pos;
      logic [7:0]  data_byte;
      logic [31:0] size_word;
      logic [31:0] count_word;
      logic        rev;
   } path_step_type;

   // Walker state after the byte, before any end-of-file clear.
   typedef struct packed {
      logic failed;
      logic done;
      logic info;
      logic data;
   } path_status_type;

   // Reads four bytes held in file order, first byte in the top bits.
   function automatic logic [31:0] read32(input logic [31:0] word, input logic be);
      return be ? word : {word[7:0], word[15:8], word[23:16], word[31:24]};
   endfunction

   // Tag as it appears in the file, byte-reversed when rev is set.
   function automatic logic [31:0] tag_order(input logic [31:0] tag, input logic rev);
      logic [31:0] r;
      int sel;
      sel = rev ? REV_XOR : 0;
      for (int i = 0; i < 4; i++) begin
         r[31 - 8*i -: 8] = tag[31 - 8*(i ^ sel) -: 8];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ sv/cmfv_if.sv @@
`default_nettype none
interface cmfv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, data_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface cmfv_rsp_if;
   logic        valid;
   logic        ready;
   logic        file_valid;
   logic        big_endian;
   logic        reversed_tags;
   logic [31:0] declared_size;
   logic [2:0]  error_code;
   modport source (output valid, file_valid, big_endian, reversed_tags, declared_size,
                   error_code, input ready);
   modport sink   (input valid, file_valid, big_endian, reversed_tags, declared_size,
                   error_code, output ready);
endinterface

interface cmfv_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] max_encoding;
   modport source (output valid, max_encoding, input ready);
   modport sink   (input valid, max_encoding, output ready);
endinterface
`default_nettype wire

@@ sv/cmfv_path.sv @@
`default_nettype none
`include "chunked_message_file_validator_unit_assert.svh"
module cmfv_path
   import cmfv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            big_endian,
   input  path_step_type   step,
   output path_status_type status
);

   logic [31:0] offs_ff, offs_in, offs_upd;
   logic [31:0] remain_ff, remain_in, remain_upd;
   logic [63:0] bh_ff, bh_in, bh_upd;
   logic        failed_ff, failed_in, failed_upd;
   logic        info_ff, info_in, info_upd;
   logic        data_ff, data_in, data_upd;

   logic [31:0] jsize, diff, span, bsize;
   logic [63:0] bh_shift;

   always_comb begin
      jsize    = read32(step.size_word, big_endian);
      diff     = step.pos - offs_ff;
      span     = jsize - offs_ff;
      bh_shift = {bh_ff[55:0], step.data_byte};
      bsize    = read32(bh_shift[31:0], big_endian);

      offs_upd   = offs_ff;
      remain_upd = remain_ff;
      bh_upd     = bh_ff;
      failed_upd = failed_ff;
      info_upd   = info_ff;
      data_upd   = data_ff;

      if (step.take) begin
         if (step.pos == HDR_LEN - 32'd1) begin
            // load the block count as the header closes
            remain_upd = read32(step.count_word, big_endian);
            if (jsize < HDR_LEN) failed_upd = 1'b1;
         end else if (step.pos >= HDR_LEN && !failed_ff && remain_ff != 32'd0
                      && step.pos >= offs_ff && diff < BLOCK_HDR_LEN) begin
            bh_upd = bh_shift;
            if (diff == BLOCK_HDR_LEN - 32'd1) begin
               if (offs_ff >= jsize || span < BLOCK_HDR_LEN || bsize < BLOCK_HDR_LEN
                   || span < bsize) begin
                  failed_upd = 1'b1;
               end else begin
                  if (bh_shift[63:32] == tag_order(TAG_INF1, step.rev)) info_upd = 1'b1;
                  if (bh_shift[63:32] == tag_order(TAG_DAT1, step.rev)) data_upd = 1'b1;
                  offs_upd   = offs_ff + bsize;
                  remain_upd = remain_ff - 32'd1;
               end
            end
         end
      end

      status.failed = failed_upd;
      status.done   = (remain_upd == 32'd0);
      status.info   = info_upd;
      status.data   = data_upd;

      // drop everything once the verdict is out
      if (step.clear) begin
         offs_in   = HDR_LEN;
         remain_in = 32'd0;
         bh_in     = 64'd0;
         failed_in = 1'b0;
         info_in   = 1'b0;
         data_in   = 1'b0;
      end else begin
         offs_in   = offs_upd;
         remain_in = remain_upd;
         bh_in     = bh_upd;
         failed_in = failed_upd;
         info_in   = info_upd;
         data_in   = data_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offs_ff   <= HDR_LEN;
         remain_ff <= 32'd0;
         bh_ff     <= 64'd0;
         failed_ff <= 1'b0;
         info_ff   <= 1'b0;
         data_ff   <= 1'b0;
      end else begin
         offs_ff   <= offs_in;
         remain_ff <= remain_in;
         bh_ff     <= bh_in;
         failed_ff <= failed_in;
         info_ff   <= info_in;
         data_ff   <= data_in;
      end
   end

   `CMFV_ASSERT_NOW(a_offs_floor, 1'b1, offs_ff >= HDR_LEN, "block offset below header end")
   `CMFV_ASSERT_NEXT(a_fail_sticks, failed_ff && !step.clear, failed_ff, "path failure lost")
   `CMFV_ASSERT_NEXT(a_remain_step, step.take && !step.clear && step.pos != HDR_LEN - 32'd1, remain_ff == $past(remain_ff) || remain_ff == $past(remain_ff) - 32'd1, "block count jumped")

endmodule
`default_nettype wire

@@ sv/chunked_message_file_validator_unit.sv @@
// Streaming checker for chunked message files. One file byte is taken per
// clock; a byte is held in the input register, and the verdict for the byte
// marked last is loaded into the result register when that byte advances out
// of the input register. Two chain
// walkers, little and big endian, run in lock step on every byte, so the
// sustained rate is one byte per cycle; input stalls only while a finished
// verdict waits in the result register and another last byte is ready behind
// it. Internal state returns to its reset values after every verdict; the
// encoding limit register keeps its value and is written through the csr
// channel, which is always ready.
`default_nettype none
`include "chunked_message_file_validator_unit_assert.svh"
module chunked_message_file_validator_unit
   import cmfv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   cmfv_req_if.sink   req_bus,
   cmfv_rsp_if.source rsp_bus,
   cmfv_csr_if.sink   csr_bus
);

   localparam logic [31:0] POS_MAX = '1;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // file state
   logic [31:0] pos_ff, pos_in, pos_upd;
   logic        ovf_ff, ovf_in, ovf_upd;
   logic [63:0] hdr0_ff, hdr0_in;
   logic [63:0] hdr1_ff, hdr1_in;
   logic [7:0]  enc_ff, enc_in;
   logic [7:0]  max_enc_ff;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        file_valid_ff, big_endian_ff, reversed_ff;
   logic [31:0] dsize_ff;
   logic [2:0]  err_ff;

   logic            advance, take, finish;
   path_step_type   step;
   path_status_type st_le, st_be;

   logic        ok_le, ok_be, v_be, v_rev;
   logic [31:0] js_le, js_be, v_dsize;
   logic [2:0]  v_err;

   assign advance = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_bus.ready);
   assign take    = advance && !ovf_ff;
   assign finish  = advance && in_last_ff;

   assign req_bus.ready = !in_valid_ff || advance;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.file_valid    = file_valid_ff;
   assign rsp_bus.big_endian    = big_endian_ff;
   assign rsp_bus.reversed_tags = reversed_ff;
   assign rsp_bus.declared_size = dsize_ff;
   assign rsp_bus.error_code    = err_ff;

   always_comb begin
      step.take       = take;
      step.clear      = finish;
      step.pos        = pos_ff;
      step.data_byte  = in_byte_ff;
      step.size_word  = hdr1_ff[63:32];
      step.count_word = hdr1_ff[31:0];
      step.rev        = (hdr0_ff[63:32] != TAG_MESG);
   end

   cmfv_path u_path_le (
      .clock      (clock),
      .reset      (reset),
      .big_endian (1'b0),
      .step       (step),
      .status     (st_le)
   );

   cmfv_path u_path_be (
      .clock      (clock),
      .reset      (reset),
      .big_endian (1'b1),
      .step       (step),
      .status     (st_be)
   );

   // header capture and position count
   always_comb begin
      pos_upd = pos_ff;
      ovf_upd = ovf_ff;
      hdr0_in = hdr0_ff;
      hdr1_in = hdr1_ff;
      enc_in  = enc_ff;
      if (take) begin
         if (pos_ff < OFS_SIZE) hdr0_in = {hdr0_ff[55:0], in_byte_ff};
         else if (pos_ff < OFS_ENC) hdr1_in = {hdr1_ff[55:0], in_byte_ff};
         if (pos_ff == OFS_ENC) enc_in = in_byte_ff;
         // saturate at the top of the counter
         if (pos_ff == POS_MAX) ovf_upd = 1'b1;
         else pos_upd = pos_ff + 32'd1;
      end
      pos_in = pos_upd;
      ovf_in = ovf_upd;
      if (finish) begin
         pos_in  = 32'd0;
         ovf_in  = 1'b0;
         hdr0_in = 64'd0;
         hdr1_in = 64'd0;
         enc_in  = 8'd0;
      end
   end

   // verdict
   always_comb begin
      js_le   = read32(hdr1_ff[63:32], 1'b0);
      js_be   = read32(hdr1_ff[63:32], 1'b1);
      ok_le   = !st_le.failed && js_le >= HDR_LEN && js_le <= pos_upd && st_le.done;
      ok_be   = !st_be.failed && js_be >= HDR_LEN && js_be <= pos_upd && st_be.done;
      v_err   = ERR_OK;
      v_be    = 1'b0;
      v_rev   = 1'b0;
      v_dsize = 32'd0;
      priority if (ovf_upd) begin
         v_err = ERR_CONTAINER;
      end else if (pos_upd < HDR_LEN) begin
         v_err = ERR_SHORT;
      end else if (!ok_le && !ok_be) begin
         v_err = ERR_CONTAINER;
      end else begin
         v_be    = !ok_le;
         v_dsize = v_be ? js_be : js_le;
         if (hdr0_ff[63:32] == TAG_MESG) v_rev = 1'b0;
         else if (hdr0_ff[63:32] == tag_order(TAG_MESG, 1'b1)) v_rev = 1'b1;
         else v_err = ERR_SIGNATURE;
         if (v_err == ERR_OK) begin
            priority if (hdr0_ff[31:0] != tag_order(TAG_BMG1, v_rev)) v_err = ERR_TYPE;
            else if (enc_ff > max_enc_ff) v_err = ERR_ENCODING;
            else if (!(v_be ? st_be.info : st_le.info)) v_err = ERR_NO_INFO;
            else if (!(v_be ? st_be.data : st_le.data)) v_err = ERR_NO_DATA;
            else v_err = ERR_OK;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.ready) in_valid_in = req_bus.valid;
      rsp_valid_in = rsp_valid_ff;
      if (finish) rsp_valid_in = 1'b1;
      else if (rsp_bus.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= 32'd0;
         ovf_ff       <= 1'b0;
         hdr0_ff      <= 64'd0;
         hdr1_ff      <= 64'd0;
         enc_ff       <= 8'd0;
         max_enc_ff   <= MAX_ENC_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         ovf_ff       <= ovf_in;
         hdr0_ff      <= hdr0_in;
         hdr1_ff      <= hdr1_in;
         enc_ff       <= enc_in;
         if (csr_bus.valid) max_enc_ff <= csr_bus.max_encoding;
      end
   end

   // payload registers: input on transfer, result on verdict only
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.last_byte;
      end
      if (finish) begin
         file_valid_ff <= (v_err == ERR_OK);
         big_endian_ff <= v_be;
         reversed_ff   <= v_rev;
         dsize_ff      <= v_dsize;
         err_ff        <= v_err;
      end
   end

   `CMFV_ASSERT_NOW(a_valid_matches_err, rsp_valid_ff, file_valid_ff == (err_ff == ERR_OK), "file_valid disagrees with error code")
   `CMFV_ASSERT_NOW(a_short_fields_zero, rsp_valid_ff && (err_ff == ERR_SHORT || err_ff == ERR_CONTAINER), !big_endian_ff && !reversed_ff && dsize_ff == 32'd0, "fields not cleared on short or container error")
   `CMFV_ASSERT_NEXT(a_clear_after_verdict, finish, pos_ff == 32'd0 && !ovf_ff, "file state kept after verdict")
   `CMFV_ASSERT_NEXT(a_input_held, in_valid_ff && !advance, in_valid_ff, "stalled byte dropped")

endmodule
`default_nettype wire

@@ tb/chunked_message_file_validator_unit_tb.sv @@
`timescale 1ns / 100ps
module chunked_message_file_validator_unit_tb;
   import cmfv_pkg::*;

   // Tags that look like INF1/DAT1 only when read in the wrong byte order.
   localparam logic [31:0] DECOY_INF1 = "1FNI";
   localparam logic [31:0] DECOY_DAT1 = "1TAD";
   localparam logic [31:0] NEAR_INF1  = "INF2";
   localparam int          HOLD_CYCLES = 300;
   localparam int          REPORT_CAP  = 40;
   localparam int          ITEM_TARGET = 850;

   typedef struct packed {
      logic        file_valid;
      logic        big_endian;
      logic        reversed_tags;
      logic [31:0] declared_size;
      logic [2:0]  error_code;
   } verdict_type;

   logic clock;
   logic reset;

   cmfv_req_if req_bus ();
   cmfv_rsp_if rsp_bus ();
   cmfv_csr_if csr_bus ();

   chunked_message_file_validator_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow of the checker state.
   logic [7:0]  enc_limit;
   logic [31:0] file_pos;
   logic        stream_overflow;
   logic [63:0] hdr_id;
   logic [63:0] hdr_sizes;
   logic [7:0]  enc_byte;
   logic [31:0] chain_ofs [2];
   logic [31:0] chain_left [2];
   logic [63:0] chain_hdr [2];
   logic        chain_fail [2];
   logic        chain_info [2];
   logic        chain_data [2];

   verdict_type verdicts_due [$];
   logic [7:0]  file_image [$];
   int          mismatch_count = 0;
   int          burst_left = 0;
   int          bytes_sent = 0;
   logic        hold_active = 1'b0;
   int          ready_phase_left = 0;
   bit          ready_choppy = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [7:0] byte_of(input logic [63:0] x, input int k);
      return x[63 - 8*k -: 8];
   endfunction

   function automatic logic [31:0] word_of(input logic [63:0] x, input int k,
                                           input logic be);
      logic [7:0] b0, b1, b2, b3;
      b0 = byte_of(x, k);
      b1 = byte_of(x, k + 1);
      b2 = byte_of(x, k + 2);
      b3 = byte_of(x, k + 3);
      return be ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
   endfunction

   function automatic logic tag_is(input logic [63:0] x, input int k, input logic [31:0] tag,
                                   input logic rev);
      int sx;
      sx = rev ? 3 : 0;
      for (int i = 0; i < 4; i++) begin
         if (byte_of(x, k + i) != tag[31 - 8*(i ^ sx) -: 8]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic clear_model();
      file_pos = '0;
      stream_overflow = 1'b0;
      hdr_id = '0;
      hdr_sizes = '0;
      enc_byte = '0;
      for (int p = 0; p < 2; p++) begin
         chain_ofs[p] = HDR_LEN;
         chain_left[p] = '0;
         chain_hdr[p] = '0;
         chain_fail[p] = 1'b0;
         chain_info[p] = 1'b0;
         chain_data[p] = 1'b0;
      end
   endtask

   // Advance the shadow state by one byte; queue the verdict on the last byte.
   task automatic track_file_byte(input logic [7:0] b, input logic last);
      logic [31:0] at, offs, jsize, bs, length;
      logic        rev, sel;
      logic        path_ok [2];
      verdict_type v;
      if (!stream_overflow) begin
         at = file_pos;
         if (at < 8) hdr_id = {hdr_id[55:0], b};
         else if (at < 16) hdr_sizes = {hdr_sizes[55:0], b};
         if (at == OFS_ENC) enc_byte = b;
         if (at == HDR_LEN - 1) begin
            for (int p = 0; p < 2; p++) begin
               chain_left[p] = word_of(hdr_sizes, 4, p[0]);
               if (word_of(hdr_sizes, 0, p[0]) < HDR_LEN) chain_fail[p] = 1'b1;
            end
         end
         if (at >= HDR_LEN) begin
            for (int p = 0; p < 2; p++) begin
               offs = chain_ofs[p];
               if (!chain_fail[p] && chain_left[p] != 0 && at >= offs
                   && at - offs < 8) begin
                  chain_hdr[p] = {chain_hdr[p][55:0], b};
                  if (at - offs == 7) begin
                     jsize = word_of(hdr_sizes, 0, p[0]);
                     bs = word_of(chain_hdr[p], 4, p[0]);
                     if (offs >= jsize || jsize - offs < 8 || bs < 8
                         || jsize - offs < bs) begin
                        chain_fail[p] = 1'b1;
                     end else begin
                        rev = !tag_is(hdr_id, 0, TAG_MESG, 1'b0);
                        if (tag_is(chain_hdr[p], 0, TAG_INF1, rev)) chain_info[p] = 1'b1;
                        if (tag_is(chain_hdr[p], 0, TAG_DAT1, rev)) chain_data[p] = 1'b1;
                        chain_ofs[p] = offs + bs;
                        chain_left[p] = chain_left[p] - 1;
                     end
                  end
               end
            end
         end
         if (at == 32'hFFFF_FFFF) stream_overflow = 1'b1;
         else file_pos = at + 1;
      end
      if (last) begin
         v = '0;
         length = file_pos;
         if (stream_overflow) begin
            v.error_code = ERR_CONTAINER;
         end else if (length < HDR_LEN) begin
            v.error_code = ERR_SHORT;
         end else begin
            for (int p = 0; p < 2; p++) begin
               jsize = word_of(hdr_sizes, 0, p[0]);
               path_ok[p] = !chain_fail[p] && jsize >= HDR_LEN && jsize <= length
                            && chain_left[p] == 0;
            end
            if (!path_ok[0] && !path_ok[1]) begin
               v.error_code = ERR_CONTAINER;
            end else begin
               sel = !path_ok[0];
               v.big_endian = sel;
               v.declared_size = word_of(hdr_sizes, 0, sel);
               if (tag_is(hdr_id, 0, TAG_MESG, 1'b0)) v.reversed_tags = 1'b0;
               else if (tag_is(hdr_id, 0, TAG_MESG, 1'b1)) v.reversed_tags = 1'b1;
               else v.error_code = ERR_SIGNATURE;
               if (v.error_code == ERR_OK) begin
                  if (!tag_is(hdr_id, 4, TAG_BMG1, v.reversed_tags)) v.error_code = ERR_TYPE;
                  else if (enc_byte > enc_limit) v.error_code = ERR_ENCODING;
                  else if (!chain_info[sel]) v.error_code = ERR_NO_INFO;
                  else if (!chain_data[sel]) v.error_code = ERR_NO_DATA;
               end
            end
         end
         v.file_valid = (v.error_code == ERR_OK);
         verdicts_due.push_back(v);
         clear_model();
      end
   endtask

   task automatic report_mismatch(input string msg);
      if (mismatch_count < REPORT_CAP) $display("%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   // Predict on every byte transfer, compare on every verdict transfer.
   always @(posedge clock) begin : scoreboard
      verdict_type got, want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            track_file_byte(req_bus.data_byte, req_bus.last_byte);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.file_valid, rsp_bus.big_endian, rsp_bus.reversed_tags,
                   rsp_bus.declared_size, rsp_bus.error_code};
            if (verdicts_due.size() == 0) begin
               report_mismatch($sformatf("verdict with none due: %h", got));
            end else begin
               want = verdicts_due.pop_front();
               if (got.file_valid !== want.file_valid)
                  report_mismatch($sformatf("file_valid %b, expected %b",
                                            got.file_valid, want.file_valid));
               if (got.big_endian !== want.big_endian)
                  report_mismatch($sformatf("big_endian %b, expected %b",
                                            got.big_endian, want.big_endian));
               if (got.reversed_tags !== want.reversed_tags)
                  report_mismatch($sformatf("reversed_tags %b, expected %b",
                                            got.reversed_tags, want.reversed_tags));
               if (got.declared_size !== want.declared_size)
                  report_mismatch($sformatf("declared_size %h, expected %h",
                                            got.declared_size, want.declared_size));
               if (got.error_code !== want.error_code)
                  report_mismatch($sformatf("error_code %0d, expected %0d",
                                            got.error_code, want.error_code));
            end
         end
      end
   end

   // Receiver: alternate steady and choppy phases; hold off entirely on request.
   always @(posedge clock) begin
      if (ready_phase_left == 0) begin
         ready_choppy = 1'($urandom_range(0, 1));
         ready_phase_left = $urandom_range(10, 80);
      end else begin
         ready_phase_left--;
      end
      rsp_bus.ready <= !hold_active && (!ready_choppy || $urandom_range(0, 2) == 0);
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= last;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
   endtask

   task automatic send_file();
      for (int i = 0; i < file_image.size(); i++)
         send_byte(file_image[i], i == file_image.size() - 1);
   endtask

   // Drop valid and let every outstanding verdict drain.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_enc_limit(input logic [7:0] v);
      wait_idle();
      csr_bus.valid <= 1'b1;
      csr_bus.max_encoding <= v;
      do @(posedge clock); while (!csr_bus.ready);
      enc_limit = v;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic put_tag(input logic [31:0] tag, input logic rev);
      for (int i = 0; i < 4; i++) file_image.push_back(tag[31 - 8*(i ^ (rev ? 3 : 0)) -: 8]);
   endtask

   task automatic put_word(input logic [31:0] w, input logic be);
      for (int i = 0; i < 4; i++) file_image.push_back(be ? w[31 - 8*i -: 8] : w[8*i +: 8]);
   endtask

   task automatic patch_word(input int at, input logic [31:0] w, input logic be);
      for (int i = 0; i < 4; i++) file_image[at + i] = be ? w[31 - 8*i -: 8] : w[8*i +: 8];
   endtask

   // Well-formed file: header, chain of small blocks, slack inside the
   // declared size and a tail beyond it.
   task automatic build_file(input logic be, input logic rev, input int n_blocks,
                             input logic with_info, input logic with_data,
                             input logic [7:0] enc, input int slack, input int tail);
      int          blk_len [$];
      logic [31:0] blk_tag [$];
      int          total;
      int          k;
      file_image.delete();
      total = HDR_LEN;
      for (int i = 0; i < n_blocks; i++) begin
         blk_len.push_back($urandom_range(8, 11));
         case ($urandom_range(0, 3))
            0: blk_tag.push_back(DECOY_INF1);
            1: blk_tag.push_back(DECOY_DAT1);
            2: blk_tag.push_back(NEAR_INF1);
            default: blk_tag.push_back($urandom);
         endcase
         total += blk_len[i];
      end
      if (n_blocks > 0) begin
         k = $urandom_range(0, n_blocks - 1);
         if (with_info) blk_tag[k] = TAG_INF1;
         if (with_data) blk_tag[(k + 1) % n_blocks] = TAG_DAT1;
      end
      put_tag(TAG_MESG, rev);
      put_tag(TAG_BMG1, rev);
      put_word(total + slack, be);
      put_word(n_blocks, be);
      file_image.push_back(enc);
      repeat (15) file_image.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < n_blocks; i++) begin
         put_tag(blk_tag[i], rev);
         put_word(blk_len[i], be);
         repeat (blk_len[i] - 8) file_image.push_back(8'($urandom_range(0, 255)));
      end
      repeat (slack + tail) file_image.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic test_short_files();
      file_image.delete();
      file_image.push_back(8'hFF);
      send_file();
      build_file(1'b0, 1'b0, 2, 1'b1, 1'b1, 8'd0, 0, 0);
      file_image = file_image[0:30];
      send_file();
   endtask

   task automatic test_well_formed();
      build_file(1'b0, 1'b0, 2, 1'b1, 1'b1, MAX_ENC_RESET, 0, 0);
      send_file();
      build_file(1'b1, 1'b0, 3, 1'b1, 1'b1, 8'd0, 4, 3);
      send_file();
      build_file(1'b0, 1'b1, 2, 1'b1, 1'b1, 8'd1, 0, 5);
      send_file();
      build_file(1'b1, 1'b1, 4, 1'b1, 1'b1, 8'd2, 2, 0);
      send_file();
   endtask

   task automatic test_header_checks();
      build_file(1'b0, 1'b0, 2, 1'b1, 1'b1, 8'd0, 0, 0);
      file_image[0] ^= 8'h01;
      send_file();
      build_file(1'b1, 1'b1, 2, 1'b1, 1'b1, 8'd0, 0, 0);
      file_image[6] ^= 8'h80;
      send_file();
      // reversed signature, type tag in file order
      build_file(1'b0, 1'b1, 2, 1'b1, 1'b1, 8'd0, 0, 0);
      patch_word(4, TAG_BMG1, 1'b1);
      send_file();
      build_file(1'b0, 1'b0, 2, 1'b1, 1'b1, MAX_ENC_RESET + 8'd1, 0, 0);
      send_file();
      build_file(1'b0, 1'b0, 2, 1'b0, 1'b1, 8'd0, 0, 0);
      send_file();
      build_file(1'b1, 1'b0, 2, 1'b1, 1'b0, 8'd0, 0, 0);
      send_file();
      // bare header, no blocks at all
      build_file(1'b0, 1'b0, 0, 1'b0, 1'b0, 8'd0, 0, 0);
      send_file();
   endtask

   task automatic test_container_checks();
      build_file(1'b0, 1'b0, 0, 1'b0, 1'b0, 8'd0, 0, 0);
      patch_word(OFS_SIZE, HDR_LEN - 1, 1'b0);
      send_file();
      build_file(1'b1, 1'b0, 2, 1'b1, 1'b1, 8'd0, 0, 0);
      patch_word(OFS_SIZE, file_image.size() + 1, 1'b1);
      send_file();
      // one block more than the declared size holds
      build_file(1'b0, 1'b0, 2, 1'b1, 1'b1, 8'd0, 6, 0);
      patch_word(OFS_SIZE + 4, 3, 1'b0);
      send_file();
      // chain still pending when the file ends
      build_file(1'b0, 1'b0, 2, 1'b1, 1'b1, 8'd0, 0, 0);
      patch_word(OFS_SIZE + 4, 32'hFFFF_FFFF, 1'b0);
      send_file();
      build_file(1'b0, 1'b0, 2, 1'b1, 1'b1, 8'd0, 0, 0);
      patch_word(HDR_LEN + 4, BLOCK_HDR_LEN - 1, 1'b0);
      send_file();
      build_file(1'b1, 1'b1, 2, 1'b1, 1'b1, 8'd0, 0, 0);
      patch_word(HDR_LEN + 4, file_image.size(), 1'b1);
      send_file();
      build_file(1'b0, 1'b0, 1, 1'b1, 1'b0, 8'd0, 0, 0);
      patch_word(OFS_SIZE, 32'hFFFF_FFFF, 1'b0);
      send_file();
   endtask

   task automatic test_encoding_limit();
      write_enc_limit(8'd0);
      build_file(1'b0, 1'b0, 2, 1'b1, 1'b1, 8'd0, 0, 0);
      send_file();
      build_file(1'b1, 1'b0, 2, 1'b1, 1'b1, 8'd1, 0, 0);
      send_file();
      write_enc_limit(8'd255);
      build_file(1'b0, 1'b1, 3, 1'b1, 1'b1, 8'd255, 1, 1);
      send_file();
   endtask

   // Hold the receiver off while one-byte files keep arriving.
   task automatic test_backpressure();
      fork
         begin
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_active <= 1'b0;
         end
         begin
            repeat (12) begin
               file_image.delete();
               file_image.push_back(8'($urandom_range(0, 255)));
               send_file();
            end
            build_file(1'b0, 1'b0, 2, 1'b1, 1'b1, 8'd0, 0, 0);
            send_file();
         end
      join
      wait_idle();
   endtask

   task automatic test_random();
      int         files, len, idx;
      logic [7:0] enc;
      files = 0;
      while (bytes_sent < ITEM_TARGET || files < 4) begin
         if (files % 10 == 9) begin
            case ($urandom_range(0, 3))
               0: write_enc_limit(8'd0);
               1: write_enc_limit(8'd255);
               default: write_enc_limit(8'($urandom_range(0, 255)));
            endcase
         end
         enc = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, enc_limit));
         build_file(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 4),
                    $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0, enc,
                    $urandom_range(0, 1) ? 0 : $urandom_range(0, 8),
                    $urandom_range(0, 1) ? 0 : $urandom_range(0, 8));
         case ($urandom_range(0, 9))
            6: begin
               idx = $urandom_range(0, (file_image.size() < 48) ? file_image.size() - 1 : 47);
               file_image[idx] ^= 8'h01 << $urandom_range(0, 7);
            end
            7: begin
               len = $urandom_range(1, file_image.size());
               file_image = file_image[0:len - 1];
            end
            8: begin
               file_image.delete();
               repeat ($urandom_range(1, 48))
                  file_image.push_back(8'($urandom_range(0, 255)));
            end
            9: patch_word($urandom_range(0, 1) ? OFS_SIZE : OFS_SIZE + 4,
                          $urandom_range(0, 96), 1'($urandom_range(0, 1)));
            default: ;
         endcase
         files++;
         send_file();
      end
   endtask

   initial begin
      #10_000_000;
      $display("chunked_message_file_validator_unit_tb: FAIL");
      $finish;
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.max_encoding = '0;
      enc_limit = MAX_ENC_RESET;
      clear_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_short_files();
      test_well_formed();
      test_header_checks();
      test_container_checks();
      test_encoding_limit();
      test_backpressure();
      test_random();
      wait_idle();
      if (mismatch_count == 0 && verdicts_due.size() == 0) begin
         $display("chunked_message_file_validator_unit_tb: PASS");
      end else begin
         $display("chunked_message_file_validator_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
